// ----- rtl/core/kab_pkg.sv -----
// Package: types, constants and arithmetic helpers for the angle/bias filter
package kab_pkg;

   localparam logic [31:0] RESET_QA = 32'd16777;
   localparam logic [31:0] RESET_QB = 32'd50332;
   localparam logic [31:0] RESET_R  = 32'd8388608;
   localparam logic [23:0] RESET_DT = 24'd83886;
   localparam logic signed [31:0] COV_ONE = 32'sd16777216;
   localparam int FRAC = 24;
   localparam int QUO_W = 57;

   localparam logic [1:0] CSR_QA = 2'd0;
   localparam logic [1:0] CSR_QB = 2'd1;
   localparam logic [1:0] CSR_R  = 2'd2;
   localparam logic [1:0] CSR_DT = 2'd3;

   typedef struct packed {
      logic signed [31:0] accel_angle;
      logic signed [31:0] gyro_rate;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] filtered_rate;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRED0, ST_PRED1, ST_PRED2, ST_PRED3, ST_INNOV,
      ST_DIV0, ST_DIV0W, ST_DIV1, ST_DIV1W,
      ST_CORR0, ST_CORR1, ST_CORR2, ST_CORR3, ST_EST, ST_OUT
   } state_type;

   typedef struct packed {
      logic     load;
      state_type step;
      logic     div_start;
      logic     finish;
      logic     rsp_take;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // round to nearest, ties up, shift by FRAC
   function automatic logic signed [65:0] rshift(input logic signed [65:0] v);
      logic signed [65:0] t;
      t = v + (66'sd1 <<< (FRAC - 1));
      return t >>> FRAC;
   endfunction

endpackage

// ----- rtl/core/kalman_angle_bias_filter.sv -----
// Top level: two-state angle and gyro bias Kalman filter
// A word is taken only while the controller is idle; it then passes the predict steps,
// two gain divisions and the correct steps, so no new word is accepted until it is finished.
// A finished word waits in the output register while the next word is taken;
// the next result holds in its last step until that register is free.
// Synchronous active-high reset: estimates zero, covariance identity, default registers.
module kalman_angle_bias_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kab_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kab_pkg::rsp_word_type rsp_data,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);

   logic [31:0] qa_ff, qb_ff, rn_ff;
   logic [23:0] dt_ff;
   kab_pkg::cmd_type cmd;
   kab_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= kab_pkg::RESET_QA;
         qb_ff <= kab_pkg::RESET_QB;
         rn_ff <= kab_pkg::RESET_R;
         dt_ff <= kab_pkg::RESET_DT;
      end else if (csr_write) begin
         case (csr_index)
            kab_pkg::CSR_QA: qa_ff <= csr_data;
            kab_pkg::CSR_QB: qb_ff <= csr_data;
            kab_pkg::CSR_R:  rn_ff <= csr_data;
            kab_pkg::CSR_DT: dt_ff <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   kab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kab_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_data),
      .qa        (qa_ff),
      .qb        (qb_ff),
      .rn        (rn_ff),
      .dt        (dt_ff),
      .rsp_word  (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

// ----- rtl/core/kab_ctrl.sv -----
// Controller: sequences predict, gain division and correct steps
module kab_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  kab_pkg::sts_type sts,
   output kab_pkg::cmd_type cmd
);

   kab_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= kab_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.step = state_ff;
      cmd.rsp_take = rsp_valid && !rsp_stall;
      req_stall = 1'b1;
      case (state_ff)
         kab_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kab_pkg::ST_PRED0;
            end
         end
         kab_pkg::ST_PRED0: state_in = kab_pkg::ST_PRED1;
         kab_pkg::ST_PRED1: state_in = kab_pkg::ST_PRED2;
         kab_pkg::ST_PRED2: state_in = kab_pkg::ST_PRED3;
         kab_pkg::ST_PRED3: state_in = kab_pkg::ST_INNOV;
         kab_pkg::ST_INNOV: state_in = kab_pkg::ST_DIV0;
         kab_pkg::ST_DIV0: begin
            cmd.div_start = 1'b1;
            state_in = kab_pkg::ST_DIV0W;
         end
         kab_pkg::ST_DIV0W: if (sts.div_done) state_in = kab_pkg::ST_DIV1;
         kab_pkg::ST_DIV1: begin
            cmd.div_start = 1'b1;
            state_in = kab_pkg::ST_DIV1W;
         end
         kab_pkg::ST_DIV1W: if (sts.div_done) state_in = kab_pkg::ST_CORR0;
         kab_pkg::ST_CORR0: state_in = kab_pkg::ST_CORR1;
         kab_pkg::ST_CORR1: state_in = kab_pkg::ST_CORR2;
         kab_pkg::ST_CORR2: state_in = kab_pkg::ST_CORR3;
         kab_pkg::ST_CORR3: state_in = kab_pkg::ST_EST;
         kab_pkg::ST_EST:   state_in = kab_pkg::ST_OUT;
         kab_pkg::ST_OUT: begin
            if (!rsp_valid || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in = kab_pkg::ST_IDLE;
            end
         end
         default: state_in = kab_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/kab_div.sv -----
// Restoring divider, one quotient bit per cycle, truncates toward zero
module kab_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  numer,
   input  logic [32:0]         denom,
   output logic                done,
   output logic signed [31:0]  quot
);

   localparam int W = kab_pkg::QUO_W;

   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  r_ff, r_in;
   logic [32:0]   d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;
   logic [W:0]    qs;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      n_in = n_ff;
      r_in = r_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done = 1'b0;
      trial = {r_ff, n_ff[W-1]} - {{(W-32){1'b0}}, d_ff};
      if (start) begin
         neg_in = numer[31];
         n_in = {(numer[31] ? (W-24)'(-$signed({numer[31], numer}))
                            : (W-24)'($signed({numer[31], numer}))), 24'd0};
         r_in = '0;
         d_in = denom;
         cnt_in = 6'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) r_in = trial[W-1:0];
         else r_in = {r_ff[W-2:0], n_ff[W-1]};
         n_in = {n_ff[W-2:0], !trial[W]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
      if (!busy_ff && !start) done = 1'b1;
      qs = neg_ff ? -{1'b0, n_ff} : {1'b0, n_ff};
      quot = kab_pkg::sat32(66'($signed(qs)));
   end

endmodule

// ----- rtl/core/kab_dp.sv -----
// Datapath: filter state, one multiplier, gain registers and result word
module kab_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  kab_pkg::cmd_type      cmd,
   output kab_pkg::sts_type      sts,
   input  kab_pkg::req_word_type req_word,
   input  logic [31:0]           qa,
   input  logic [31:0]           qb,
   input  logic [31:0]           rn,
   input  logic [23:0]           dt,
   output kab_pkg::rsp_word_type rsp_word,
   output logic                  rsp_valid
);

   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] acc_ff, acc_in, gyr_ff, gyr_in, err_ff, err_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic signed [33:0] e_ff, e_in;
   logic               epos_ff, epos_in;
   logic               vld_ff, vld_in;
   kab_pkg::rsp_word_type out_ff, out_in;
   logic signed [33:0] ma;
   logic signed [32:0] mb;
   logic signed [66:0] prod;
   logic signed [65:0] rs;
   logic signed [32:0] rate;
   logic               div_start, div_done;
   logic signed [31:0] div_num, quot;

   assign rate = 33'(gyr_ff) - 33'(bias_ff);
   assign prod = ma * mb;
   assign rs = kab_pkg::rshift(66'(prod));

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.step)
         kab_pkg::ST_PRED0: begin
            ma = 34'(kab_pkg::sat32(66'(rate)));
            mb = 33'($signed({1'b0, dt}));
         end
         kab_pkg::ST_PRED1: begin
            ma = 34'($signed({1'b0, qa})) - 34'(p01_ff) - 34'(p10_ff);
            mb = 33'($signed({1'b0, dt}));
         end
         kab_pkg::ST_PRED2: begin
            ma = 34'(p11_ff);
            mb = 33'($signed({1'b0, dt}));
         end
         kab_pkg::ST_PRED3: begin
            ma = 34'($signed({1'b0, qb}));
            mb = 33'($signed({1'b0, dt}));
         end
         kab_pkg::ST_CORR0: begin ma = 34'(k0_ff); mb = 33'(t0_ff); end
         kab_pkg::ST_CORR1: begin ma = 34'(k0_ff); mb = 33'(t1_ff); end
         kab_pkg::ST_CORR2: begin ma = 34'(k1_ff); mb = 33'(t0_ff); end
         kab_pkg::ST_CORR3: begin ma = 34'(k1_ff); mb = 33'(t1_ff); end
         kab_pkg::ST_EST:   begin ma = 34'(k0_ff); mb = 33'(err_ff); end
         kab_pkg::ST_OUT:   begin ma = 34'(k1_ff); mb = 33'(err_ff); end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   assign div_start = cmd.div_start;
   assign div_num = (cmd.step == kab_pkg::ST_DIV0) ? p00_ff : p10_ff;

   kab_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (e_ff[32:0]),
      .done  (div_done),
      .quot  (quot)
   );

   assign sts.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff <= '0;
         bias_ff <= '0;
         p00_ff <= kab_pkg::COV_ONE;
         p01_ff <= '0;
         p10_ff <= '0;
         p11_ff <= kab_pkg::COV_ONE;
         vld_ff <= 1'b0;
      end else begin
         ang_ff <= ang_in;
         bias_ff <= bias_in;
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         vld_ff <= vld_in;
      end
      acc_ff <= acc_in;
      gyr_ff <= gyr_in;
      err_ff <= err_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      e_ff <= e_in;
      epos_ff <= epos_in;
      out_ff <= out_in;
   end

   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      acc_in = acc_ff; gyr_in = gyr_ff; err_in = err_ff;
      k0_in = k0_ff; k1_in = k1_ff; t0_in = t0_ff; t1_in = t1_ff;
      e_in = e_ff; epos_in = epos_ff;
      vld_in = vld_ff; out_in = out_ff;
      if (cmd.rsp_take) vld_in = 1'b0;
      if (cmd.load) begin
         acc_in = req_word.accel_angle;
         gyr_in = req_word.gyro_rate;
      end
      case (cmd.step)
         kab_pkg::ST_PRED0: ang_in = kab_pkg::sat32(66'(ang_ff) + rs);
         kab_pkg::ST_PRED1: p00_in = kab_pkg::sat32(66'(p00_ff) + rs);
         kab_pkg::ST_PRED2: begin
            p01_in = kab_pkg::sat32(66'(p01_ff) - rs);
            p10_in = kab_pkg::sat32(66'(p10_ff) - rs);
         end
         kab_pkg::ST_PRED3: p11_in = kab_pkg::sat32(66'(p11_ff) + rs);
         kab_pkg::ST_INNOV: begin
            err_in = kab_pkg::sat32(66'(acc_ff) - 66'(ang_ff));
            e_in = 34'($signed({1'b0, rn})) + 34'(p00_ff);
            epos_in = ($signed(34'($signed({1'b0, rn})) + 34'(p00_ff)) > 34'sd0);
            t0_in = p00_ff;
            t1_in = p01_ff;
         end
         kab_pkg::ST_DIV1: k0_in = epos_ff ? quot : 32'sd0;
         kab_pkg::ST_CORR0: begin
            k1_in = epos_ff ? quot : 32'sd0;
            p00_in = kab_pkg::sat32(66'(p00_ff) - rs);
         end
         kab_pkg::ST_CORR1: p01_in = kab_pkg::sat32(66'(p01_ff) - rs);
         kab_pkg::ST_CORR2: p10_in = kab_pkg::sat32(66'(p10_ff) - rs);
         kab_pkg::ST_CORR3: p11_in = kab_pkg::sat32(66'(p11_ff) - rs);
         kab_pkg::ST_EST: ang_in = kab_pkg::sat32(66'(ang_ff) + rs);
         default: ;
      endcase
      if (cmd.finish) begin
         bias_in = kab_pkg::sat32(66'(bias_ff) + rs);
         out_in.filtered_angle = ang_ff;
         out_in.filtered_rate = kab_pkg::sat32(66'(gyr_ff) - 66'(bias_in));
         vld_in = 1'b1;
      end
   end

   assign rsp_word = out_ff;
   assign rsp_valid = vld_ff;

endmodule

// ----- verif/kalman_angle_bias_filter_tb.sv -----
// Testbench for the angle and gyro bias Kalman filter: directed table, then fixed and random words
`timescale 1ns / 100ps

module kalman_angle_bias_filter_tb;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   kab_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   kab_pkg::rsp_word_type rsp_data;
   logic                  csr_write = 1'b0;
   logic [1:0]            csr_index = kab_pkg::CSR_QA;
   logic [31:0]           csr_data = '0;

   kalman_angle_bias_filter dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter state held by the predictor
   logic [31:0] qa_q, qb_q, r_q;
   logic [23:0] dt_q;
   longint angle_est, bias_est, p00, p01, p10, p11;

   kab_pkg::rsp_word_type expected_words[$];
   int  errors = 0;
   int  send_idle = 0;
   int  recv_stall = 0;
   logic flag_check;
   kab_pkg::rsp_word_type fixed_word;
   bit  fixed_pending[$];
   kab_pkg::rsp_word_type fixed_words[$];

   function automatic longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint rnd24(longint v);
      return (v + (64'sd1 <<< 23)) >>> 24;
   endfunction

   task automatic filter_reset();
      qa_q = kab_pkg::RESET_QA; qb_q = kab_pkg::RESET_QB;
      r_q = kab_pkg::RESET_R; dt_q = kab_pkg::RESET_DT;
      angle_est = 0; bias_est = 0;
      p00 = kab_pkg::COV_ONE; p01 = 0; p10 = 0; p11 = kab_pkg::COV_ONE;
   endtask

   function automatic kab_pkg::rsp_word_type filter_update(kab_pkg::req_word_type w);
      longint dt, gyro, accel, rate, d, err, e, k0, k1, t0, t1;
      kab_pkg::rsp_word_type o;
      dt = dt_q; gyro = w.gyro_rate; accel = w.accel_angle;
      rate = sat(gyro - bias_est);
      angle_est = sat(angle_est + rnd24(rate * dt));
      d = longint'(qa_q) - p01 - p10;
      p00 = sat(p00 + rnd24(d * dt));
      d = rnd24(p11 * dt);
      p01 = sat(p01 - d);
      p10 = sat(p10 - d);
      p11 = sat(p11 + rnd24(longint'(qb_q) * dt));
      err = sat(accel - angle_est);
      e = longint'(r_q) + p00;
      k0 = 0; k1 = 0;
      if (e > 0) begin
         k0 = sat((p00 <<< 24) / e);
         k1 = sat((p10 <<< 24) / e);
      end
      t0 = p00; t1 = p01;
      p00 = sat(p00 - rnd24(k0 * t0));
      p01 = sat(p01 - rnd24(k0 * t1));
      p10 = sat(p10 - rnd24(k1 * t0));
      p11 = sat(p11 - rnd24(k1 * t1));
      angle_est = sat(angle_est + rnd24(k0 * err));
      bias_est = sat(bias_est + rnd24(k1 * err));
      rate = sat(gyro - bias_est);
      o.filtered_angle = angle_est[31:0];
      o.filtered_rate = rate[31:0];
      return o;
   endfunction

   // accept and check result words
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word angle %h rate %h", rsp_data.filtered_angle,
                   rsp_data.filtered_rate);
            errors++;
         end else begin
            fixed_word = expected_words.pop_front();
            flag_check = fixed_pending.pop_front();
            if (flag_check) fixed_word = fixed_words.pop_front();
            if (rsp_data.filtered_angle !== fixed_word.filtered_angle) begin
               $error("filtered_angle expected %h actual %h", fixed_word.filtered_angle,
                      rsp_data.filtered_angle);
               errors++;
            end
            if (rsp_data.filtered_rate !== fixed_word.filtered_rate) begin
               $error("filtered_rate expected %h actual %h", fixed_word.filtered_rate,
                      rsp_data.filtered_rate);
               errors++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   task automatic send_word(kab_pkg::req_word_type w, bit typed,
                            kab_pkg::rsp_word_type typed_word);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(filter_update(w));
      fixed_pending.push_back(typed);
      if (typed) fixed_words.push_back(typed_word);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         kab_pkg::CSR_QA: qa_q = val;
         kab_pkg::CSR_QB: qb_q = val;
         kab_pkg::CSR_R:  r_q = val;
         kab_pkg::CSR_DT: dt_q = val[23:0];
         default: ;
      endcase
   endtask

   typedef struct {
      logic [31:0]           accel;
      logic [31:0]           gyro;
      bit                    typed;
      kab_pkg::rsp_word_type result;
   } stim_row_type;

   stim_row_type directed_rows[11] = '{
      // zero input from reset state: nothing moves
      '{32'h0, 32'h0, 1'b1, '{32'h0, 32'h0}},
      '{32'h7fffffff, 32'h0, 1'b0, '0},
      '{32'h80000000, 32'h0, 1'b0, '0},
      '{32'h0, 32'h7fffffff, 1'b0, '0},
      '{32'h0, 32'h80000000, 1'b0, '0},
      '{32'h7fffffff, 32'h7fffffff, 1'b0, '0},
      '{32'h80000000, 32'h80000000, 1'b0, '0},
      '{32'h7fffffff, 32'h80000000, 1'b0, '0},
      '{32'h00010000, 32'hffff0000, 1'b0, '0},
      '{32'hffffffff, 32'h00000001, 1'b0, '0},
      '{32'h00050000, 32'h00020000, 1'b0, '0}
   };

   task automatic random_words(int count);
      kab_pkg::req_word_type w;
      repeat (count) begin
         case ($urandom_range(3))
            0: w = {$urandom(), $urandom()};
            1: w = {32'($signed(20'($urandom())) ), 32'($signed(18'($urandom())))};
            2: w = {32'($urandom_range(1) ? 32'h7fffffff : 32'h80000000), $urandom()};
            default: w = {32'($signed(24'($urandom()))), 32'($signed(22'($urandom())))};
         endcase
         send_word(w, 1'b0, '0);
      end
   endtask

   initial begin
      filter_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_word({directed_rows[i].accel, directed_rows[i].gyro},
                   directed_rows[i].typed, directed_rows[i].result);
      drain();
      // freeze prediction and zero measure noise
      write_reg(kab_pkg::CSR_DT, 32'h0);
      write_reg(kab_pkg::CSR_R, 32'h0);
      send_word({32'h00030000, 32'h00010000}, 1'b0, '0);
      send_word({32'h80000000, 32'h7fffffff}, 1'b0, '0);
      drain();
      // largest values: saturation; the large R keeps the innovation variance positive
      write_reg(kab_pkg::CSR_QA, 32'hffffffff);
      write_reg(kab_pkg::CSR_QB, 32'hffffffff);
      write_reg(kab_pkg::CSR_R, 32'hffffffff);
      write_reg(kab_pkg::CSR_DT, 32'h00ffffff);
      random_words(10);
      drain();
      write_reg(kab_pkg::CSR_QA, 32'h0);
      write_reg(kab_pkg::CSR_QB, 32'h0);
      write_reg(kab_pkg::CSR_R, 32'h1);
      write_reg(kab_pkg::CSR_DT, 32'h1);
      random_words(10);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 24 : 64) : 0;
         recv_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 24 : 64) : 0;
         write_reg(kab_pkg::CSR_QA, $urandom_range(1) ? $urandom_range(200000) : $urandom());
         write_reg(kab_pkg::CSR_QB, $urandom_range(1) ? $urandom_range(200000) : $urandom());
         write_reg(kab_pkg::CSR_R,
                   $urandom_range(1) ? $urandom_range(1, 32'h04000000) : $urandom());
         write_reg(kab_pkg::CSR_DT,
                   $urandom_range(1) ? $urandom_range(1, 300000) : $urandom());
         random_words(240);
         drain();
         random_words(240);
         drain();
      end
      send_idle = 0;
      recv_stall = 0;
      write_reg(kab_pkg::CSR_QA, kab_pkg::RESET_QA);
      write_reg(kab_pkg::CSR_QB, kab_pkg::RESET_QB);
      write_reg(kab_pkg::CSR_R, kab_pkg::RESET_R);
      write_reg(kab_pkg::CSR_DT, 32'(kab_pkg::RESET_DT));
      random_words(30);
      drain();
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/kab_pkg.sv
rtl/core/kab_ctrl.sv
rtl/core/kab_div.sv
rtl/core/kab_dp.sv
rtl/core/kalman_angle_bias_filter.sv
verif/kalman_angle_bias_filter_tb.sv
